// ===== sv/tccs_pkg.sv =====
// tccs_pkg: shared types and constants of the text console cursor/scroll unit
// field widths, character codes, operation codes, cursor command and status
// no dependencies
package tccs_pkg;

  // field widths fixed by the item format
  localparam int unsigned OP_W   = 2;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned CELL_W = 16;
  localparam int unsigned ATTR_W = 8;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd32;

  // attribute after reset and the blank cell written by the reset pass
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
  localparam logic [CELL_W-1:0] RESET_CELL = {ATTR_RESET, CH_BLANK};

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  // commands to the cursor tracker
  typedef enum logic [2:0] {
    CUR_HOLD     = 3'd0,
    CUR_ADVANCE  = 3'd1,
    CUR_BACK     = 3'd2,
    CUR_NEWLINE  = 3'd3,
    CUR_HOME     = 3'd4,
    CUR_LAST_ROW = 3'd5
  } cur_cmd_e;

  // cursor status flags back to the sequencer
  typedef struct packed {
    logic at_end;     // cursor is one past the last cell
    logic at_zero;    // cursor is on the first cell
    logic nl_scroll;  // a newline from here would leave the screen
  } cur_status_t;

endpackage

// ===== sv/tccs_ram.sv =====
// tccs_ram: generic single write port, single read port memory
// read data registered
// depends on nothing
module tccs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tccs_addr_unit.sv =====
// tccs_addr_unit: the shared address adder and end-of-sweep compare
// used for sweep pointers, scroll source addresses and the backspace address
// depends on nothing
module tccs_addr_unit #(
  parameter int unsigned W = 11
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] limit_i,
  output logic [W-1:0] sum_o,
  output logic         last_o
);

  // one add, wraps modulo the width
  assign sum_o  = a_i + b_i;

  // the operand has reached the end of its sweep
  assign last_o = (a_i == limit_i);

endmodule

// ===== sv/tccs_cursor.sv =====
// tccs_cursor: cursor position and column tracker
// keeps the column alongside the cell index so a newline needs no division
// depends on tccs_pkg
module tccs_cursor
  import tccs_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned CELLS   = 2000
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cur_cmd_e                   cmd_i,
  output logic [$clog2(CELLS+1)-1:0] cursor_o,
  output cur_status_t                status_o
);

  localparam int unsigned CW = $clog2(CELLS + 1);
  localparam int unsigned KW = $clog2(COLUMNS);

  logic [CW-1:0] cursor_q, cursor_d;
  logic [KW-1:0] col_q, col_d;
  logic [CW-1:0] row_start;

  // start of the current row
  assign row_start = cursor_q - CW'(col_q);

  assign status_o.at_end    = (cursor_q == CW'(CELLS));
  assign status_o.at_zero   = (cursor_q == '0);
  assign status_o.nl_scroll = (row_start >= CW'(CELLS - COLUMNS));

  // next cursor and column
  always_comb begin
    cursor_d = cursor_q;
    col_d    = col_q;
    unique case (cmd_i)
      CUR_HOLD: begin
      end
      CUR_ADVANCE: begin
        cursor_d = cursor_q + CW'(1);
        col_d    = (col_q == KW'(COLUMNS - 1)) ? '0 : col_q + KW'(1);
      end
      CUR_BACK: begin
        cursor_d = cursor_q - CW'(1);
        col_d    = (col_q == '0) ? KW'(COLUMNS - 1) : col_q - KW'(1);
      end
      CUR_NEWLINE: begin
        cursor_d = row_start + CW'(COLUMNS);
        col_d    = '0;
      end
      CUR_HOME: begin
        cursor_d = '0;
        col_d    = '0;
      end
      CUR_LAST_ROW: begin
        cursor_d = CW'(CELLS - COLUMNS);
        col_d    = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      col_q    <= '0;
    end else begin
      cursor_q <= cursor_d;
      col_q    <= col_d;
    end
  end

  assign cursor_o = cursor_q;

endmodule

// ===== sv/text_console_cursor_scroll_unit.sv =====
// text_console_cursor_scroll_unit: top level of the text console engine
// sequencer, screen memory, shared address unit and cursor tracker
// depends on tccs_pkg, tccs_ram, tccs_addr_unit, tccs_cursor
//
// A screen of COLUMNS by ROWS cells (attribute high byte, character low
// byte) held in one memory with one write and one registered read port,
// plus a cursor. One item is handled at a time; in_stall_o is high from the
// transfer of an item until its result has been loaded into the output
// register, which may still be waiting while the next item is taken. An
// in range read takes its data from the registered read port, and a clear
// writes every cell with the current attribute. A put or newline that
// scrolls does one memory read then one write per copied cell through the
// single address adder and one write per blanked cell; a put that scrolls
// then writes its character. After reset a clearing pass over all
// COLUMNS*ROWS cells (2000 at the defaults) blanks the screen while no
// item is taken; attribute writes on the configuration port are taken at
// any time.
module text_console_cursor_scroll_unit
  import tccs_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // item input
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [IDX_W-1:0]  cell_index_i,
  // result output
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CELL_W-1:0] cell_value_o,
  output logic [IDX_W-1:0]  cursor_position_o,
  // attribute register write
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [ATTR_W-1:0] cfg_data_i
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CW    = $clog2(CELLS + 1);

  typedef enum logic [8:0] {
    S_INIT      = 9'b000000001,
    S_IDLE      = 9'b000000010,
    S_READ      = 9'b000000100,
    S_FILL      = 9'b000001000,
    S_SCR_RD    = 9'b000010000,
    S_SCR_WR    = 9'b000100000,
    S_SCR_BLANK = 9'b001000000,
    S_PUT       = 9'b010000000,
    S_DONE      = 9'b100000000
  } state_e;

  state_e            state_q, state_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic              pend_q, pend_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic [CELL_W-1:0] res_q, res_d;
  logic [ATTR_W-1:0] attr_q;
  logic              out_valid_q, out_valid_d;
  logic [CELL_W-1:0] cell_value_q;
  logic [IDX_W-1:0]  cursor_position_q;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;
  logic [AW-1:0]     au_a, au_b, au_lim, au_sum;
  logic              au_last;
  cur_cmd_e          cur_cmd;
  logic [CW-1:0]     cursor;
  cur_status_t       cur_status;
  logic [AW-1:0]     cur_addr;
  logic [CELL_W-1:0] blank;
  logic              in_xfer, out_free, in_range;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign blank       = {attr_q, CH_BLANK};
  assign cur_addr    = AW'(cursor);
  assign in_range    = (32'(cell_index_i) < 32'(CELLS));

  // screen memory
  tccs_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // shared address adder
  tccs_addr_unit #(
    .W(AW)
  ) u_addr (
    .a_i    (au_a),
    .b_i    (au_b),
    .limit_i(au_lim),
    .sum_o  (au_sum),
    .last_o (au_last)
  );

  // cursor tracker
  tccs_cursor #(
    .COLUMNS(COLUMNS),
    .CELLS  (CELLS)
  ) u_cursor (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cur_cmd),
    .cursor_o(cursor),
    .status_o(cur_status)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    pend_d      = pend_q;
    char_d      = char_q;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = ptr_q;
    ram_wdata   = blank;
    au_a        = ptr_q;
    au_b        = AW'(1);
    au_lim      = AW'(CELLS - 1);
    ram_raddr   = au_sum;
    cur_cmd     = CUR_HOLD;
    unique case (state_q)
      // blank the screen with the reset attribute
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = RESET_CELL;
        if (au_last) begin
          ptr_d   = '0;
          state_d = S_IDLE;
        end else begin
          ptr_d = au_sum;
        end
      end
      // take an item and decode it
      S_IDLE: begin
        if (in_xfer) begin
          ptr_d   = '0;
          res_d   = '0;
          state_d = S_DONE;
          unique case (op_i)
            OP_PUT: begin
              if (char_code_i == CH_NEWLINE) begin
                if (cur_status.nl_scroll) begin
                  pend_d  = 1'b0;
                  state_d = S_SCR_RD;
                end else begin
                  cur_cmd = CUR_NEWLINE;
                end
              end else if (char_code_i == CH_BACKSPACE) begin
                if (!cur_status.at_zero) begin
                  au_a      = cur_addr;
                  au_b      = '1;
                  ram_we    = 1'b1;
                  ram_waddr = au_sum;
                  cur_cmd   = CUR_BACK;
                end
              end else if (cur_status.at_end) begin
                pend_d  = 1'b1;
                char_d  = char_code_i;
                state_d = S_SCR_RD;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cur_addr;
                ram_wdata = {attr_q, char_code_i};
                cur_cmd   = CUR_ADVANCE;
              end
            end
            OP_CLEAR: begin
              state_d = S_FILL;
            end
            OP_READ: begin
              if (in_range) begin
                ram_raddr = AW'(cell_index_i);
                state_d   = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      // registered read data is here
      S_READ: begin
        res_d   = ram_rdata;
        state_d = S_DONE;
      end
      // clear sweep with the current attribute
      S_FILL: begin
        ram_we = 1'b1;
        if (au_last) begin
          cur_cmd = CUR_HOME;
          ptr_d   = '0;
          state_d = S_DONE;
        end else begin
          ptr_d = au_sum;
        end
      end
      // scroll: fetch the cell one row below
      S_SCR_RD: begin
        au_b    = AW'(COLUMNS);
        state_d = S_SCR_WR;
      end
      // scroll: store it one row up
      S_SCR_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        au_lim    = AW'(CELLS - COLUMNS - 1);
        if (au_last) begin
          ptr_d   = AW'(CELLS - COLUMNS);
          state_d = S_SCR_BLANK;
        end else begin
          ptr_d   = au_sum;
          state_d = S_SCR_RD;
        end
      end
      // scroll: blank the bottom row
      S_SCR_BLANK: begin
        ram_we = 1'b1;
        if (au_last) begin
          cur_cmd = CUR_LAST_ROW;
          ptr_d   = '0;
          state_d = pend_q ? S_PUT : S_DONE;
        end else begin
          ptr_d = au_sum;
        end
      end
      // character held over a scroll
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = cur_addr;
        ram_wdata = {attr_q, char_q};
        cur_cmd   = CUR_ADVANCE;
        pend_d    = 1'b0;
        state_d   = S_DONE;
      end
      // hand the result to the output register
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if ((state_q == S_DONE) && out_free) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      attr_q      <= ATTR_RESET;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        attr_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    res_q  <= res_d;
    if ((state_q == S_DONE) && out_free) begin
      cell_value_q      <= res_q;
      cursor_position_q <= IDX_W'(cursor);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign cell_value_o      = cell_value_q;
  assign cursor_position_o = cursor_position_q;

endmodule
